// ===== design/skhd_pkg.sv =====
`default_nettype none
package skhd_pkg;

   // Table geometry.
   localparam int TABLE_SIZE  = 4096;
   localparam int MAX_KEY_LEN = 32;
   localparam int SLOT_W      = $clog2(TABLE_SIZE);
   localparam int LEN_W       = $clog2(MAX_KEY_LEN + 2);
   localparam int WORDS       = MAX_KEY_LEN / 4;
   localparam int WORD_IDX_W  = $clog2(WORDS + 1);
   localparam int BYTE_IDX_W  = $clog2(MAX_KEY_LEN);

   // Hash mixing constants.
   localparam logic [31:0] MIX_M = 32'h5bd1e995;
   localparam int MIX_R     = 24;
   localparam int FIN_R1    = 13;
   localparam int FIN_R2    = 15;

   // Operation codes.
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_FOUND    = 3'd0;
   localparam logic [2:0] ST_ABSENT   = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_PRESENT  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_TOO_LONG = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   typedef logic [MAX_KEY_LEN-1:0][7:0] key_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  key_byte;
      logic        key_last;
      logic [15:0] history_position;
      logic [11:0] slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] result_slot;
      logic [15:0] stored_position;
      logic [31:0] collision_count;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [15:0]      position;
   } meta_type;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] len;
   } hash_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } hash_rsp_type;

endpackage
`default_nettype wire

// ===== design/skhd_hash.sv =====
`default_nettype none
module skhd_hash import skhd_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  hash_req_type hash_req,
   input  key_type      key_vec,
   output hash_rsp_type hash_rsp
);

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_K1   = 3'd1;
   localparam logic [2:0] H_K2   = 3'd2;
   localparam logic [2:0] H_HM   = 3'd3;
   localparam logic [2:0] H_TAIL = 3'd4;
   localparam logic [2:0] H_F1   = 3'd5;
   localparam logic [2:0] H_F2   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [31:0]           h_ff, h_in;
   logic [31:0]           k_ff, k_in;
   logic [WORD_IDX_W-1:0] widx_ff, widx_in;
   logic [WORD_IDX_W-1:0] nwords_ff, nwords_in;
   logic [1:0]            rest_ff, rest_in;
   logic                  done_ff, done_in;
   logic [31:0]           word;
   logic [31:0]           tail;
   logic [31:0]           mul_a;
   logic [31:0]           product;
   logic [WORD_IDX_W-1:0] widx_next;

   // Current little-endian word of the key and its masked tail.
   always_comb begin
      word = 32'(key_vec[BYTE_IDX_W'({widx_ff, 2'b00}) +: 4]);
      unique case (rest_ff)
         2'd1:    tail = {24'd0, word[7:0]};
         2'd2:    tail = {16'd0, word[15:0]};
         2'd3:    tail = {8'd0, word[23:0]};
         default: tail = 32'd0;
      endcase
   end

   // One shared constant multiplier; its operand depends on the step.
   always_comb begin
      unique case (state_ff)
         H_K1:    mul_a = word;
         H_K2:    mul_a = k_ff ^ (k_ff >> MIX_R);
         H_HM:    mul_a = h_ff;
         H_TAIL:  mul_a = h_ff ^ tail;
         H_F1:    mul_a = h_ff ^ (h_ff >> FIN_R1);
         default: mul_a = h_ff;
      endcase
      product = 32'(64'(mul_a) * 64'(MIX_M));
   end

   // Step sequencer.
   always_comb begin
      state_in  = state_ff;
      h_in      = h_ff;
      k_in      = k_ff;
      widx_in   = widx_ff;
      nwords_in = nwords_ff;
      rest_in   = rest_ff;
      done_in   = 1'b0;
      widx_next = widx_ff + 1'b1;
      unique case (state_ff)
         H_IDLE: begin
            if (hash_req.start) begin
               h_in      = 32'(hash_req.len);
               widx_in   = '0;
               nwords_in = WORD_IDX_W'(hash_req.len >> 2);
               rest_in   = hash_req.len[1:0];
               if ((hash_req.len >> 2) != '0) begin
                  state_in = H_K1;
               end else if (hash_req.len[1:0] != 2'd0) begin
                  state_in = H_TAIL;
               end else begin
                  state_in = H_F1;
               end
            end
         end
         H_K1: begin
            k_in     = product;
            state_in = H_K2;
         end
         H_K2: begin
            k_in     = product;
            state_in = H_HM;
         end
         H_HM: begin
            h_in    = product ^ k_ff;
            widx_in = widx_next;
            if (widx_next != nwords_ff) begin
               state_in = H_K1;
            end else if (rest_ff != 2'd0) begin
               state_in = H_TAIL;
            end else begin
               state_in = H_F1;
            end
         end
         H_TAIL: begin
            h_in     = product;
            state_in = H_F1;
         end
         H_F1: begin
            h_in     = product;
            state_in = H_F2;
         end
         H_F2: begin
            h_in     = h_ff ^ (h_ff >> FIN_R2);
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      h_ff      <= h_in;
      k_ff      <= k_in;
      widx_ff   <= widx_in;
      nwords_ff <= nwords_in;
      rest_ff   <= rest_in;
   end

   assign hash_rsp.done  = done_ff;
   assign hash_rsp.value = h_ff;

endmodule
`default_nettype wire

// ===== design/string_key_hash_dictionary_core.sv =====
// Key bytes that are not last are stored in the pending key. A last byte
// hashes the key in the shared multiplier, word by word, then tail and
// finalizer, then reads and checks one probed slot after another, then
// writes the output word. A slot read is a registered read to the output.
// Clearing the table sweeps the valid memory at one slot a cycle, as does reset,
// taking no request word; reset clears the collision count, a table clear keeps it.
`default_nettype none
module string_key_hash_dictionary_core import skhd_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output rsp_type rsp_payload
);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_HASH = 3'd2;
   localparam logic [2:0] S_PRD  = 3'd3;
   localparam logic [2:0] S_PCHK = 3'd4;
   localparam logic [2:0] S_RD   = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // Slot memories.
   logic     valid_mem [TABLE_SIZE];
   meta_type meta_mem  [TABLE_SIZE];
   key_type  key_mem   [TABLE_SIZE];
   logic     valid_rd_ff;
   meta_type meta_rd_ff;
   key_type  key_rd_ff;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] probe_ff, probe_in;
   logic [SLOT_W-1:0] home_ff, home_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              clr_resp_ff, clr_resp_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [LEN_W-1:0]  klen_ff, klen_in;
   key_type           pkey_ff, pkey_in;
   logic [1:0]        op_ff, op_in;
   logic [15:0]       hpos_ff, hpos_in;
   logic [31:0]       coll_ff, coll_in;
   logic [2:0]        res_status_ff, res_status_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [15:0]       res_pos_ff, res_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic [LEN_W-1:0]  len_next;
   logic [SLOT_W-1:0] mem_addr;
   logic              valid_we;
   logic              valid_wd;
   logic [SLOT_W-1:0] valid_wa;
   logic              ins_we;
   logic              key_match;
   hash_req_type      hash_req;
   hash_rsp_type      hash_rsp;

   skhd_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .hash_req (hash_req),
      .key_vec  (pkey_ff),
      .hash_rsp (hash_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign mem_addr  = (state_ff == S_IDLE) ? req_payload.slot[SLOT_W-1:0] : probe_ff;

   // Compare the stored row with the pending key over the key length only.
   always_comb begin
      key_match = (meta_rd_ff.len == klen_ff);
      for (int i = 0; i < MAX_KEY_LEN; i++) begin
         if ((LEN_W'(i) < klen_ff) && (key_rd_ff[i] != pkey_ff[i])) begin
            key_match = 1'b0;
         end
      end
   end

   // Main sequencer.
   always_comb begin
      state_in      = state_ff;
      probe_in      = probe_ff;
      home_in       = home_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      clr_resp_in   = clr_resp_ff;
      plen_in       = plen_ff;
      klen_in       = klen_ff;
      pkey_in       = pkey_ff;
      op_in         = op_ff;
      hpos_in       = hpos_ff;
      coll_in       = coll_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      valid_we      = 1'b0;
      valid_wd      = 1'b0;
      valid_wa      = probe_ff;
      ins_we        = 1'b0;
      hash_req      = '0;
      len_next      = plen_ff + ((plen_ff <= LEN_W'(MAX_KEY_LEN)) ? 1'b1 : 1'b0);
      unique case (state_ff)
         S_CLR: begin
            valid_we = 1'b1;
            valid_wa = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(TABLE_SIZE - 1)) begin
               if (clr_resp_ff) begin
                  res_status_in = ST_DONE;
                  res_slot_in   = '0;
                  res_pos_in    = '0;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_payload.operation)
                  OP_CLEAR: begin
                     plen_in     = '0;
                     clr_in      = '0;
                     clr_resp_in = 1'b1;
                     state_in    = S_CLR;
                  end
                  OP_READ: begin
                     probe_in = req_payload.slot[SLOT_W-1:0];
                     state_in = S_RD;
                  end
                  default: begin
                     if (plen_ff < LEN_W'(MAX_KEY_LEN)) begin
                        pkey_in[BYTE_IDX_W'(plen_ff)] = req_payload.key_byte;
                     end
                     plen_in = len_next;
                     if (req_payload.key_last) begin
                        plen_in = '0;
                        klen_in = len_next;
                        op_in   = req_payload.operation;
                        hpos_in = req_payload.history_position;
                        if (len_next > LEN_W'(MAX_KEY_LEN)) begin
                           res_status_in = ST_TOO_LONG;
                           res_slot_in   = '0;
                           res_pos_in    = '0;
                           state_in      = S_OUT;
                        end else begin
                           hash_req.start = 1'b1;
                           hash_req.len   = len_next;
                           state_in       = S_HASH;
                        end
                     end
                  end
               endcase
            end
         end
         S_HASH: begin
            if (hash_rsp.done) begin
               probe_in = hash_rsp.value[SLOT_W-1:0];
               home_in  = hash_rsp.value[SLOT_W-1:0];
               cnt_in   = '0;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (!valid_rd_ff) begin
               res_slot_in = probe_ff;
               state_in    = S_OUT;
               if (op_ff == OP_LOOKUP) begin
                  res_status_in = ST_ABSENT;
                  res_pos_in    = '0;
               end else begin
                  valid_we      = 1'b1;
                  valid_wd      = 1'b1;
                  ins_we        = 1'b1;
                  res_status_in = ST_INSERTED;
                  res_pos_in    = hpos_ff;
                  if (probe_ff != home_ff) begin
                     coll_in = coll_ff + 1'b1;
                  end
               end
            end else if (key_match) begin
               res_status_in = (op_ff == OP_LOOKUP) ? ST_FOUND : ST_PRESENT;
               res_slot_in   = probe_ff;
               res_pos_in    = meta_rd_ff.position;
               state_in      = S_OUT;
            end else if (cnt_ff == SLOT_W'(TABLE_SIZE - 1)) begin
               res_status_in = ST_FULL;
               res_slot_in   = '0;
               res_pos_in    = '0;
               state_in      = S_OUT;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               state_in = S_PRD;
            end
         end
         S_RD: begin
            res_status_in = ST_DONE;
            res_slot_in   = probe_ff;
            res_pos_in    = meta_rd_ff.position;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = res_status_ff;
               rsp_in.result_slot     = 12'(res_slot_ff);
               rsp_in.stored_position = res_pos_ff;
               rsp_in.collision_count = coll_ff;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Slot memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_wa] <= valid_wd;
      end
      valid_rd_ff <= valid_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (ins_we) begin
         meta_mem[probe_ff] <= '{len: klen_ff, position: hpos_ff};
      end
      meta_rd_ff <= meta_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (ins_we) begin
         key_mem[probe_ff] <= pkey_ff;
      end
      key_rd_ff <= key_mem[mem_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         plen_ff      <= '0;
         coll_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_resp_ff  <= clr_resp_in;
         plen_ff      <= plen_in;
         coll_ff      <= coll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      probe_ff      <= probe_in;
      home_ff       <= home_in;
      cnt_ff        <= cnt_in;
      klen_ff       <= klen_in;
      pkey_ff       <= pkey_in;
      op_ff         <= op_in;
      hpos_ff       <= hpos_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pos_ff    <= res_pos_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
